// ----- sv/epts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epts_pkg: shared types, constants and functions
// Types and saturating helpers for the electron pair term sum unit.
// ----------------------------------------------------------------------------
package epts_pkg;

   localparam int POLY_TERMS_DEF = 3;

   localparam logic [2:0] CSR_UP_COUNT     = 3'd0;
   localparam logic [2:0] CSR_PADE_NUMER   = 3'd1;
   localparam logic [2:0] CSR_PADE_DENOM   = 3'd2;
   localparam logic [2:0] CSR_COEF_SQ      = 3'd3;
   localparam logic [2:0] CSR_COEF_CUBE    = 3'd4;
   localparam logic [2:0] CSR_COEF_QUART   = 3'd5;
   localparam logic [2:0] CSR_ASYM_OPP     = 3'd6;
   localparam logic [2:0] CSR_ASYM_SAME    = 3'd7;

   localparam logic [6:0] MUL_X_STEPS    = 7'd40;
   localparam logic [6:0] MUL_COEF_STEPS = 7'd48;
   localparam logic [6:0] DIV_STEPS      = 7'd88;

   localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NUM,
      ST_DEN,
      ST_DIV,
      ST_ADD_RAT,
      ST_ADD_ASYM,
      ST_POW,
      ST_TERM,
      ST_ADD_TERM,
      ST_EMIT
   } fsm_state_type;

   typedef struct packed {
      logic        start;
      logic        is_div;
      logic [6:0]  steps;
      logic [87:0] op_a;
      logic [63:0] op_b;
   } mdu_req_type;

   typedef struct packed {
      logic         done;
      logic [111:0] result;
   } mdu_rsp_type;

   // {flag, value}
   function automatic logic [64:0] to_signed(input logic [87:0] mag, input logic neg);
      logic [64:0] r;
      if (neg) begin
         if (mag > {24'd0, S64_MIN}) r = {1'b1, S64_MIN};
         else r = {1'b0, 64'(-mag[63:0])};
      end else begin
         if (mag > {24'd0, S64_MAX}) r = {1'b1, S64_MAX};
         else r = {1'b0, mag[63:0]};
      end
      return r;
   endfunction

   function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      logic [64:0] r;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) r = {1'b1, (a[63] ? S64_MIN : S64_MAX)};
      else r = {1'b0, s};
      return r;
   endfunction

   function automatic logic [47:0] mag48(input logic [47:0] v);
      return v[47] ? 48'(-v) : v;
   endfunction

endpackage

// ----- sv/epts_mdu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epts_mdu: iterative multiply / divide unit
// One shared 112 bit adder: shift-add multiply or restoring divide, one bit
// per cycle.
// ----------------------------------------------------------------------------
module epts_mdu (
   input  logic                 clock,
   input  logic                 reset,
   input  epts_pkg::mdu_req_type req,
   output epts_pkg::mdu_rsp_type rsp
);

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic         div_ff, div_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [111:0] prod_ff, prod_in;
   logic [111:0] mcand_ff, mcand_in;
   logic [63:0]  mplier_ff, mplier_in;
   logic [63:0]  rem_ff, rem_in;

   logic [111:0] add_a, add_b, sum;
   logic [64:0]  rem_sh;
   logic         ge;

   assign rem_sh = {rem_ff, mcand_ff[87]};
   assign add_a  = div_ff ? {47'd0, rem_sh} : prod_ff;
   assign add_b  = div_ff ? ~{48'd0, mplier_ff} : mcand_ff;
   assign sum    = add_a + add_b + {111'd0, div_ff};
   assign ge     = ~sum[111];

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      div_in    = div_ff;
      cnt_in    = cnt_ff;
      prod_in   = prod_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      if (req.start) begin
         busy_in   = 1'b1;
         div_in    = req.is_div;
         cnt_in    = req.steps;
         prod_in   = '0;
         mcand_in  = {24'd0, req.op_a};
         mplier_in = req.op_b;
         rem_in    = '0;
      end else if (busy_ff) begin
         mcand_in = {mcand_ff[110:0], 1'b0};
         if (div_ff) begin
            rem_in  = ge ? sum[63:0] : rem_sh[63:0];
            prod_in = {prod_ff[110:0], ge};
         end else begin
            if (mplier_ff[0]) prod_in = sum;
            mplier_in = {1'b0, mplier_ff[63:1]};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff    <= div_in;
      cnt_ff    <= cnt_in;
      prod_ff   <= prod_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = prod_ff;

endmodule

// ----- sv/electron_pair_term_sum_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// electron_pair_term_sum_unit: pair term accumulator
// Adds f*b0*x/(1+b1*x) - asym + b2*x^2 + b3*x^3 + b4*x^4 per electron pair
// into a saturating walker sum, emitted on the last pair.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one electron pair per beat (indices, distance, tlast marks
//   the last pair of a walker). rsp_* returns the walker sum (tdata) and the
//   saturation flag (tuser) once per walker.
//   csr_* writes the spin split and the coefficients; write only while idle.
// Sequence:
//   Each pair runs two 40-step multiplies, an 88-step divide (skipped when
//   the numerator product or the denominator is zero), then per power term
//   a 40-step and a 48-step multiply, all on the one shared bit-serial
//   multiply/divide unit, then the accumulate steps. A new pair is accepted
//   only after the last one is through; req_tready is high only when idle.
// Reset:
//   Synchronous; clears the state, the coefficient registers, the sum and the flag.
// Stall:
//   A result waits in the output register; the next pair is still accepted
//   and worked on, and only a last pair's emit waits if the register is still full.
// ----------------------------------------------------------------------------
module electron_pair_term_sum_unit #(
   parameter int POLY_TERMS = epts_pkg::POLY_TERMS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // row_elec[9:0], col_elec[19:10], distance[59:20]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // walker_sum[63:0]
   output logic        rsp_tuser,   // saturated[0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   epts_pkg::fsm_state_type state_ff, state_in;

   logic [10:0] up_ff;
   logic [47:0] numer_ff, denom_ff, sq_ff, cube_ff, quart_ff, asym_opp_ff, asym_same_ff;

   logic        launched_ff;
   logic [39:0] x_ff;
   logic        same_ff, last_ff;
   logic [1:0]  k_ff;
   logic [87:0] num_ff;
   logic [63:0] dm_ff;
   logic        dneg_ff;
   logic [63:0] term_ff, pw_ff, sum_ff;
   logic        ovf_ff;
   logic        rsp_tvalid_ff;
   logic [63:0] rsp_sum_ff;
   logic        rsp_sat_ff;

   epts_pkg::mdu_req_type mdu_req;
   epts_pkg::mdu_rsp_type mdu_rsp;

   logic        accept, div_skip, emit_free, poly_done;
   logic [47:0] cm;
   logic        cneg;
   logic [63:0] pq, dval;
   logic [87:0] qv;
   logic [64:0] rat_res, term_res, add_res;

   assign accept    = req_tvalid && req_tready;
   assign div_skip  = (num_ff == '0) || (dm_ff == '0);
   assign emit_free = !rsp_tvalid_ff || rsp_tready;
   assign poly_done = (int'(k_ff) + 1 >= POLY_TERMS);

   always_comb begin
      case (k_ff)
         2'd0:    cm = sq_ff;
         2'd1:    cm = cube_ff;
         default: cm = quart_ff;
      endcase
   end
   assign cneg = cm[47];

   assign pq       = mdu_rsp.result[95:32];
   assign dval     = 64'h1_0000_0000 + (denom_ff[47] ? 64'(-pq) : pq);
   assign qv       = same_ff ? {1'b0, mdu_rsp.result[87:1]} : mdu_rsp.result[87:0];
   assign rat_res  = epts_pkg::to_signed(qv, numer_ff[47] ^ dneg_ff);
   assign term_res = epts_pkg::to_signed({8'd0, mdu_rsp.result[111:32]}, cneg);

   always_comb begin
      case (state_ff)
         epts_pkg::ST_ADD_ASYM:
            add_res = epts_pkg::sat_add(sum_ff,
               64'(-{{16{(same_ff ? asym_same_ff[47] : asym_opp_ff[47])}},
                     (same_ff ? asym_same_ff : asym_opp_ff)}));
         default:
            add_res = epts_pkg::sat_add(sum_ff, term_ff);
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         epts_pkg::ST_IDLE:     if (accept) state_in = epts_pkg::ST_NUM;
         epts_pkg::ST_NUM:      if (mdu_rsp.done) state_in = epts_pkg::ST_DEN;
         epts_pkg::ST_DEN:      if (mdu_rsp.done) state_in = epts_pkg::ST_DIV;
         epts_pkg::ST_DIV:      if (div_skip || mdu_rsp.done) state_in = epts_pkg::ST_ADD_RAT;
         epts_pkg::ST_ADD_RAT:  state_in = epts_pkg::ST_ADD_ASYM;
         epts_pkg::ST_ADD_ASYM: state_in = (POLY_TERMS > 0) ? epts_pkg::ST_POW : epts_pkg::ST_EMIT;
         epts_pkg::ST_POW:      if (mdu_rsp.done) state_in = epts_pkg::ST_TERM;
         epts_pkg::ST_TERM:     if (mdu_rsp.done) state_in = epts_pkg::ST_ADD_TERM;
         epts_pkg::ST_ADD_TERM: state_in = poly_done ? epts_pkg::ST_EMIT : epts_pkg::ST_POW;
         epts_pkg::ST_EMIT:     if (!last_ff || emit_free) state_in = epts_pkg::ST_IDLE;
         default:               state_in = epts_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready     = (state_ff == epts_pkg::ST_IDLE);
      mdu_req.start  = 1'b0;
      mdu_req.is_div = 1'b0;
      mdu_req.steps  = epts_pkg::MUL_X_STEPS;
      mdu_req.op_a   = '0;
      mdu_req.op_b   = {24'd0, x_ff};
      case (state_ff)
         epts_pkg::ST_NUM: begin
            mdu_req.start = !launched_ff;
            mdu_req.op_a  = {40'd0, epts_pkg::mag48(numer_ff)};
         end
         epts_pkg::ST_DEN: begin
            mdu_req.start = !launched_ff;
            mdu_req.op_a  = {40'd0, epts_pkg::mag48(denom_ff)};
         end
         epts_pkg::ST_DIV: begin
            mdu_req.start  = !launched_ff && !div_skip;
            mdu_req.is_div = 1'b1;
            mdu_req.steps  = epts_pkg::DIV_STEPS;
            mdu_req.op_a   = num_ff;
            mdu_req.op_b   = dm_ff;
         end
         epts_pkg::ST_POW: begin
            mdu_req.start = !launched_ff;
            mdu_req.op_a  = (k_ff == 2'd0) ? {48'd0, x_ff} : {24'd0, pw_ff};
         end
         epts_pkg::ST_TERM: begin
            mdu_req.start = !launched_ff;
            mdu_req.steps = epts_pkg::MUL_COEF_STEPS;
            mdu_req.op_a  = {24'd0, pw_ff};
            mdu_req.op_b  = {16'd0, epts_pkg::mag48(cm)};
         end
         default: ;
      endcase
   end

   epts_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .req   (mdu_req),
      .rsp   (mdu_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= epts_pkg::ST_IDLE;
         launched_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         sum_ff        <= '0;
         ovf_ff        <= 1'b0;
         up_ff         <= '0;
         numer_ff      <= '0;
         denom_ff      <= '0;
         sq_ff         <= '0;
         cube_ff       <= '0;
         quart_ff      <= '0;
         asym_opp_ff   <= '0;
         asym_same_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (mdu_req.start) launched_ff <= 1'b1;
         else if (mdu_rsp.done) launched_ff <= 1'b0;
         if (state_ff == epts_pkg::ST_EMIT && last_ff && emit_free) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tvalid_ff && rsp_tready) rsp_tvalid_ff <= 1'b0;

         if (csr_we) begin
            case (csr_index)
               epts_pkg::CSR_UP_COUNT:   up_ff        <= csr_wdata[10:0];
               epts_pkg::CSR_PADE_NUMER: numer_ff     <= csr_wdata;
               epts_pkg::CSR_PADE_DENOM: denom_ff     <= csr_wdata;
               epts_pkg::CSR_COEF_SQ:    sq_ff        <= csr_wdata;
               epts_pkg::CSR_COEF_CUBE:  cube_ff      <= csr_wdata;
               epts_pkg::CSR_COEF_QUART: quart_ff     <= csr_wdata;
               epts_pkg::CSR_ASYM_OPP:   asym_opp_ff  <= csr_wdata;
               epts_pkg::CSR_ASYM_SAME:  asym_same_ff <= csr_wdata;
               default: ;
            endcase
         end

         case (state_ff)
            epts_pkg::ST_DIV: begin
               if (num_ff == '0) begin
                  term_ff <= '0;
               end else if (dm_ff == '0) begin
                  term_ff <= numer_ff[47] ? epts_pkg::S64_MIN : epts_pkg::S64_MAX;
                  ovf_ff  <= 1'b1;
               end else if (mdu_rsp.done) begin
                  term_ff <= rat_res[63:0];
                  if (rat_res[64]) ovf_ff <= 1'b1;
               end
            end
            epts_pkg::ST_TERM: begin
               if (mdu_rsp.done) begin
                  term_ff <= term_res[63:0];
                  if (term_res[64]) ovf_ff <= 1'b1;
               end
            end
            epts_pkg::ST_ADD_RAT, epts_pkg::ST_ADD_ASYM, epts_pkg::ST_ADD_TERM: begin
               sum_ff <= add_res[63:0];
               if (add_res[64]) ovf_ff <= 1'b1;
            end
            epts_pkg::ST_EMIT: begin
               if (last_ff && emit_free) begin
                  sum_ff <= '0;
                  ovf_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end

      if (accept) begin
         x_ff    <= req_tdata[59:20];
         last_ff <= req_tlast;
         same_ff <= ({1'b0, req_tdata[9:0]} < up_ff) || ({1'b0, req_tdata[19:10]} >= up_ff);
         k_ff    <= 2'd0;
      end
      if (state_ff == epts_pkg::ST_NUM && mdu_rsp.done) num_ff <= mdu_rsp.result[87:0];
      if (state_ff == epts_pkg::ST_DEN && mdu_rsp.done) begin
         dneg_ff <= dval[63];
         dm_ff   <= dval[63] ? 64'(-dval) : dval;
      end
      if (state_ff == epts_pkg::ST_POW && mdu_rsp.done) pw_ff <= mdu_rsp.result[95:32];
      if (state_ff == epts_pkg::ST_ADD_TERM) k_ff <= k_ff + 2'd1;
      if (state_ff == epts_pkg::ST_EMIT && last_ff && emit_free) begin
         rsp_sum_ff <= sum_ff;
         rsp_sat_ff <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_sum_ff;
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tlast  = 1'b1;

   a_idle_unit_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == epts_pkg::ST_IDLE) |-> !launched_ff)
      else $error("shared unit still running while idle");

   a_done_launched: assert property (@(posedge clock) disable iff (reset)
      mdu_rsp.done |-> launched_ff)
      else $error("unit done without a launch");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == epts_pkg::ST_EMIT && last_ff && emit_free)
         |=> (rsp_tvalid_ff && sum_ff == '0 && !ovf_ff))
      else $error("emit did not load result and clear sum");

endmodule

// ----- dv/electron_pair_term_sum_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// electron_pair_term_sum_unit_tb: self-checking bench for the pair term unit
// Drives electron pairs in bursts with gaps. A bit-exact model of the Pade
// term and the saturating walker sum predicts each emitted sum and flag, but directed rows carry fixed results.
// Coefficient sets are changed between phases while the unit is idle. These
// include the zero-denominator case, the all-max and all-min extremes, and
// random sets. The receiver stalls on a pattern of its own, with one long
// hold-off that backs up the input.
// ----------------------------------------------------------------------------
module electron_pair_term_sum_unit_tb;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int SETTLE_CYCLES  = 1200;
   localparam int HOLD_CYCLES    = 6000;
   localparam int N_RANDOM       = 1000;

   typedef struct {
      logic [63:0] sum;
      logic        sat;
   } walker_result_type;

   typedef struct {
      int          cfg_sel;
      logic [9:0]  row;
      logic [9:0]  col;
      logic [39:0] pair_dist;
      logic        last;
      logic        typed;
      logic [63:0] exp_sum;
      logic        exp_sat;
   } pair_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // row_elec[9:0], col_elec[19:10], distance[59:20]
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // walker_sum[63:0]
   logic        rsp_tuser;   // saturated[0]
   logic        rsp_tlast;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [47:0] csr_wdata;

   electron_pair_term_sum_unit dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // model state
   logic [10:0] m_up;
   logic [47:0] m_coef [5];
   logic [47:0] m_asym_opp, m_asym_same;
   logic [63:0] m_sum;
   logic        m_sat;

   walker_result_type sum_q [$];
   int n_err = 0;
   int n_mism = 0;
   int burst_left = 0;

   function automatic logic [63:0] sx48(input logic [47:0] v);
      return {{16{v[47]}}, v};
   endfunction

   function automatic logic [63:0] clamp64(input logic [127:0] m, input logic neg,
                                           inout logic flag);
      if (neg) begin
         if (m > 128'(epts_pkg::S64_MIN)) begin flag = 1'b1; return epts_pkg::S64_MIN; end
         return -m[63:0];
      end
      if (m > 128'(epts_pkg::S64_MAX)) begin flag = 1'b1; return epts_pkg::S64_MAX; end
      return m[63:0];
   endfunction

   function automatic logic [63:0] add64(input logic [63:0] a, input logic [63:0] b,
                                         inout logic flag);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         flag = 1'b1;
         return a[63] ? epts_pkg::S64_MIN : epts_pkg::S64_MAX;
      end
      return s;
   endfunction

   function automatic logic [63:0] pade_term(input logic [39:0] x, input logic half,
                                             inout logic flag);
      logic [63:0] v0, v1, m0, m1, pq, d, dm;
      logic nneg, bneg, dneg;
      logic [127:0] num, q;
      v0 = sx48(m_coef[0]);
      v1 = sx48(m_coef[1]);
      nneg = v0[63];
      bneg = v1[63];
      m0 = nneg ? -v0 : v0;
      m1 = bneg ? -v1 : v1;
      num = 128'(m0) * 128'(x);
      q = (128'(m1) * 128'(x)) >> 32;
      pq = q[63:0];
      d = 64'h1_0000_0000 + (bneg ? -pq : pq);
      dneg = d[63];
      dm = dneg ? -d : d;
      if (num == 128'd0) return 64'd0;
      if (dm == 64'd0) begin
         flag = 1'b1;
         return nneg ? epts_pkg::S64_MIN : epts_pkg::S64_MAX;
      end
      q = num / 128'(dm);
      if (half) q = q >> 1;
      return clamp64(q, nneg ^ dneg, flag);
   endfunction

   // advances the walker state; returns 1 when a sum is emitted
   function automatic bit accumulate_pair(input logic [9:0] i, input logic [9:0] j,
                                          input logic [39:0] x, input logic last,
                                          output walker_result_type res);
      logic same, flag;
      logic [63:0] acc, cm, cv;
      logic [63:0] pw [3];
      logic [127:0] p;
      flag = 1'b0;
      same = (11'(i) < m_up) || (11'(j) >= m_up);
      acc = add64(m_sum, pade_term(x, same, flag), flag);
      acc = add64(acc, -sx48(same ? m_asym_same : m_asym_opp), flag);
      p = (128'(x) * 128'(x)) >> 32;
      pw[0] = p[63:0];
      p = (128'(pw[0]) * 128'(x)) >> 32;
      pw[1] = p[63:0];
      p = (128'(pw[1]) * 128'(x)) >> 32;
      pw[2] = p[63:0];
      for (int t = 0; t < epts_pkg::POLY_TERMS_DEF && t < 3; t++) begin
         cv = sx48(m_coef[2 + t]);
         cm = cv[63] ? -cv : cv;
         p = (128'(cm) * 128'(pw[t])) >> 32;
         acc = add64(acc, clamp64(p, cv[63], flag), flag);
      end
      m_sum = acc;
      if (flag) m_sat = 1'b1;
      res.sum = m_sum;
      res.sat = m_sat;
      if (!last) return 0;
      m_sum = 64'd0;
      m_sat = 1'b0;
      return 1;
   endfunction

   task automatic write_regs(input logic [47:0] vals [8]);
      for (int k = 0; k < 8; k++) begin
         csr_we    <= 1'b1;
         csr_index <= 3'(k);
         csr_wdata <= vals[k];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      m_up       = vals[epts_pkg::CSR_UP_COUNT][10:0];
      m_coef[0]  = vals[epts_pkg::CSR_PADE_NUMER];
      m_coef[1]  = vals[epts_pkg::CSR_PADE_DENOM];
      m_coef[2]  = vals[epts_pkg::CSR_COEF_SQ];
      m_coef[3]  = vals[epts_pkg::CSR_COEF_CUBE];
      m_coef[4]  = vals[epts_pkg::CSR_COEF_QUART];
      m_asym_opp  = vals[epts_pkg::CSR_ASYM_OPP];
      m_asym_same = vals[epts_pkg::CSR_ASYM_SAME];
   endtask

   task automatic drain_idle();
      req_tvalid <= 1'b0;
      while (sum_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_pair(input logic [9:0] i, input logic [9:0] j, input logic [39:0] x,
                            input logic last, input logic typed, input walker_result_type tv);
      walker_result_type res;
      req_tdata  <= {4'd0, x, j, i};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (accumulate_pair(i, j, x, last, res)) sum_q.push_back(typed ? tv : res);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         burst_left = $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic [47:0] rand_coef();
      logic [47:0] v;
      case ($urandom_range(0, 5))
         0: v = 48'h7FFF_FFFF_FFFF;
         1: v = 48'h8000_0000_0000;
         2: v = 48'({$urandom(), $urandom()});
         default: begin
            v = 48'({$urandom(), $urandom()} >> $urandom_range(14, 44));
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic logic [39:0] rand_dist();
      case ($urandom_range(0, 4))
         0: return 40'({$urandom(), $urandom()});
         1: return 40'($urandom()) >> $urandom_range(0, 31);
         default: return 40'({$urandom(), $urandom()} >> $urandom_range(28, 63));
      endcase
   endfunction

   // result side: stall pattern, one long hold-off, checking
   int rcv_cyc = 0;
   int rcv_hold = 0;
   int rcv_count = 0;
   bit held = 0;
   int idle_cyc = 0;

   always @(posedge clock) begin
      walker_result_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rcv_count++;
            if (sum_q.size() == 0) begin
               n_err++;
               if (n_mism < 10) $display("unexpected walker sum %h", rsp_tdata);
               n_mism++;
            end else begin
               e = sum_q.pop_front();
               if (e.sum !== rsp_tdata || e.sat !== rsp_tuser) begin
                  n_err++;
                  if (n_mism < 10)
                     $display("walker mismatch: exp sum %h sat %b, got sum %h sat %b",
                              e.sum, e.sat, rsp_tdata, rsp_tuser);
                  n_mism++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cyc = 0;
         else idle_cyc++;
         if (idle_cyc >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
         rcv_cyc++;
         if (rcv_count == 40 && !held) begin
            held = 1;
            rcv_hold = HOLD_CYCLES;
         end
         if (rcv_hold > 0) begin
            rcv_hold--;
            rsp_tready <= 1'b0;
         end else begin
            case ((rcv_cyc / 3000) % 3)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   logic [47:0] cfg_set [4][8];
   pair_row_type dir_tbl [$];

   initial begin
      walker_result_type tv;
      logic [47:0] vals [8];
      int cur_cfg;
      int walk_len;
      logic [9:0] ri, rj;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      m_up = '0;
      foreach (m_coef[k]) m_coef[k] = '0;
      m_asym_opp = '0;
      m_asym_same = '0;
      m_sum = '0;
      m_sat = 1'b0;

      cfg_set[0] = '{default: 48'd0};
      cfg_set[1] = '{48'd512, 48'h1_0000_0000, -48'h1_0000_0000, 48'd0, 48'd0, 48'd0,
                     48'd0, 48'd0};
      cfg_set[2] = '{48'd1024, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                     48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                     48'h7FFF_FFFF_FFFF};
      cfg_set[3] = '{48'd0, 48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000,
                     48'h8000_0000_0000, 48'h8000_0000_0000, 48'h8000_0000_0000,
                     48'h8000_0000_0000};

      // reset registers: every term is zero
      dir_tbl.push_back('{0, 10'd1023, 10'd0, 40'hFF_FFFF_FFFF, 1, 1, 64'd0, 0});
      dir_tbl.push_back('{0, 10'd1, 10'd0, 40'd0, 1, 1, 64'd0, 0});
      dir_tbl.push_back('{0, 10'd0, 10'd1023, 40'hFF_FFFF_FFFF, 0, 1, 64'd0, 0});
      dir_tbl.push_back('{0, 10'd512, 10'd511, 40'h1_0000_0000, 1, 1, 64'd0, 0});
      // zero denominator on an opposite-spin pair
      dir_tbl.push_back('{1, 10'd600, 10'd100, 40'h1_0000_0000, 1, 1, epts_pkg::S64_MAX, 1});
      dir_tbl.push_back('{1, 10'd600, 10'd100, 40'd0, 1, 0, 64'd0, 0});
      dir_tbl.push_back('{1, 10'd300, 10'd100, 40'h1_0000_0000, 1, 0, 64'd0, 0});
      dir_tbl.push_back('{1, 10'd700, 10'd600, 40'h0_8000_0000, 0, 0, 64'd0, 0});
      dir_tbl.push_back('{1, 10'd600, 10'd511, 40'hFF_FFFF_FFFF, 1, 0, 64'd0, 0});
      dir_tbl.push_back('{1, 10'd3, 10'd900, 40'h3_0000_0000, 1, 0, 64'd0, 0});
      dir_tbl.push_back('{2, 10'd1023, 10'd1022, 40'hFF_FFFF_FFFF, 1, 0, 64'd0, 0});
      dir_tbl.push_back('{2, 10'd5, 10'd4, 40'd1, 1, 0, 64'd0, 0});
      dir_tbl.push_back('{2, 10'd0, 10'd0, 40'd0, 1, 0, 64'd0, 0});
      dir_tbl.push_back('{3, 10'd1023, 10'd0, 40'hFF_FFFF_FFFF, 1, 0, 64'd0, 0});
      dir_tbl.push_back('{3, 10'd2, 10'd1, 40'h1_0000_0000, 0, 0, 64'd0, 0});
      dir_tbl.push_back('{3, 10'd9, 10'd8, 40'h0_0000_FFFF, 1, 0, 64'd0, 0});

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cur_cfg = -1;
      foreach (dir_tbl[n]) begin
         if (dir_tbl[n].cfg_sel != cur_cfg) begin
            if (cur_cfg >= 0) drain_idle();
            cur_cfg = dir_tbl[n].cfg_sel;
            write_regs(cfg_set[cur_cfg]);
         end
         tv.sum = dir_tbl[n].exp_sum;
         tv.sat = dir_tbl[n].exp_sat;
         send_pair(dir_tbl[n].row, dir_tbl[n].col, dir_tbl[n].pair_dist, dir_tbl[n].last,
                   dir_tbl[n].typed, tv);
      end

      for (int ph = 0; ph < 8; ph++) begin
         drain_idle();
         foreach (vals[k]) vals[k] = rand_coef();
         case (ph)
            0: vals[epts_pkg::CSR_UP_COUNT] = 48'd0;
            1: vals[epts_pkg::CSR_UP_COUNT] = 48'd1024;
            default: vals[epts_pkg::CSR_UP_COUNT] = 48'($urandom_range(0, 1024));
         endcase
         write_regs(vals);
         for (int n = 0; n < N_RANDOM / 8; n += walk_len) begin
            walk_len = $urandom_range(1, 8);
            for (int w = 0; w < walk_len; w++) begin
               if ($urandom_range(0, 99) < 85) begin
                  ri = 10'($urandom_range(1, 1023));
                  rj = 10'($urandom_range(0, ri - 1));
               end else begin
                  ri = 10'($urandom());
                  rj = 10'($urandom());
               end
               send_pair(ri, rj, rand_dist(), w == walk_len - 1, 1'b0, tv);
            end
         end
      end

      req_tvalid <= 1'b0;
      while (sum_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sum_q.size() != 0) n_err++;
      if (n_err == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
